// ===== design/tsrs_pkg.sv =====
// shared types, constants and register map table for the temperature sensor register slave
// no dependencies; imported by every module of the block
package tsrs_pkg;

	// register map geometry
	localparam int MAP_ENTRIES = 22;
	localparam int IDX_W = 5;
	typedef logic [IDX_W-1:0] map_idx_t;

	// stream widths
	localparam int IN_DATA_W = 32;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 16;
	localparam int TEMP_W = 9;

	// request kinds carried in tuser
	typedef enum logic [1:0] {
		REQ_MATCH = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2,
		REQ_TEMP  = 2'd3
	} req_t;

	// fixed entries and config bits
	localparam map_idx_t IDX_REMOTE = map_idx_t'(0);
	localparam map_idx_t IDX_LOCAL = map_idx_t'(1);
	localparam map_idx_t IDX_CONFIG = map_idx_t'(3);
	localparam int EXT_MODE_BIT = 2;

	// temperature clamp limits
	localparam logic signed [TEMP_W-1:0] EXT_MIN = -9'sd64;
	localparam logic signed [TEMP_W-1:0] EXT_MAX = 9'sd191;
	localparam logic signed [TEMP_W-1:0] EXT_OFFSET = 9'sd64;
	localparam logic signed [TEMP_W-1:0] STD_MAX = 9'sd127;

	// map table: read address, write address, presence flags and power-on value
	localparam logic [7:0] MAP_RD_ADDR [MAP_ENTRIES] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00, 8'h10,
		8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h19, 8'h20, 8'h21, 8'h22, 8'h23, 8'hfe
	};
	localparam logic [MAP_ENTRIES-1:0] MAP_RD_EN = 22'b11_1111_1111_1101_1111_1111;
	localparam logic [7:0] MAP_WR_ADDR [MAP_ENTRIES] = '{
		8'h00, 8'h00, 8'h00, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h00,
		8'h11, 8'h12, 8'h13, 8'h14, 8'h00, 8'h19, 8'h20, 8'h21, 8'h22, 8'h23, 8'h00
	};
	localparam logic [MAP_ENTRIES-1:0] MAP_WR_EN = 22'b01_1111_0111_1011_1111_1000;
	localparam logic [7:0] MAP_INIT [MAP_ENTRIES] = '{
		8'h00, 8'h00, 8'h00, 8'h04, 8'h08, 8'h55, 8'h00, 8'h55, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6c, 8'h55, 8'h0a, 8'h01, 8'h00, 8'h59
	};

	// pointer decode result
	typedef struct packed {
		logic     rd_valid;
		map_idx_t rd_idx;
		logic     wr_valid;
		map_idx_t wr_idx;
	} ptr_dec_t;

endpackage

// ===== design/tsrs_ptr_decode.sv =====
// pointer byte decode against the constant register map
// depends on tsrs_pkg for the map table and the decode struct
module tsrs_ptr_decode
	import tsrs_pkg::*;
(
	input  logic [7:0] ptr,
	output ptr_dec_t   dec
);

	// scan from the top so the lowest matching entry wins, read address before write
	always_comb begin
		dec = '0;
		for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
			if (MAP_RD_EN[i] && MAP_RD_ADDR[i] == ptr) begin
				dec.rd_valid = 1'b1;
				dec.rd_idx = map_idx_t'(i);
				dec.wr_valid = MAP_WR_EN[i] && (MAP_WR_ADDR[i] == MAP_RD_ADDR[i]);
				dec.wr_idx = map_idx_t'(i);
			end else if (MAP_WR_EN[i] && MAP_WR_ADDR[i] == ptr) begin
				dec.rd_valid = 1'b0;
				dec.rd_idx = map_idx_t'(i);
				dec.wr_valid = 1'b1;
				dec.wr_idx = map_idx_t'(i);
			end
		end
	end

endmodule

// ===== design/tsrs_temp_encode.sv =====
// temperature to register byte encoding, standard or extended range
// depends on tsrs_pkg for the clamp limits
module tsrs_temp_encode
	import tsrs_pkg::*;
(
	input  logic signed [TEMP_W-1:0] temp,
	input  logic                     ext_mode,
	output logic [7:0]               code
);

	logic signed [TEMP_W-1:0] shifted;

	assign shifted = temp + EXT_OFFSET;

	// clamp, then offset in extended mode
	always_comb begin
		if (ext_mode) begin
			if (temp < EXT_MIN) begin
				code = 8'h00;
			end else if (temp > EXT_MAX) begin
				code = 8'hff;
			end else begin
				code = shifted[7:0];
			end
		end else begin
			if (temp < 0) begin
				code = 8'h00;
			end else if (temp > STD_MAX) begin
				code = STD_MAX[7:0];
			end else begin
				code = temp[7:0];
			end
		end
	end

endmodule

// ===== design/temp_sensor_register_slave.sv =====
// top level of the temperature sensor register slave: input register, map state, result register
// depends on tsrs_pkg, tsrs_ptr_decode and tsrs_temp_encode
// each item passes through the input register and then the result register; one item per cycle
// while the result side takes results
// one result per item, in order; backpressure on the result side stalls the input register
// reset (arst_n low, asynchronous) loads the map power-on values, pointer at entry 0,
// both targets valid and both temperatures 0
module temp_sensor_register_slave
	import tsrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] dir_is_write, [8:1] data_byte, [17:9] remote_value, [26:18] local_value, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] read_data, [8] write_dropped, rest zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// input register
	logic                     valid_s1;
	req_t                     req_s1;
	logic                     dir_s1;
	logic [7:0]               data_s1;
	logic signed [TEMP_W-1:0] remote_s1;
	logic signed [TEMP_W-1:0] local_s1;

	// result register
	logic       valid_s2;
	logic [7:0] rd_s2;
	logic       drop_s2;

	// map state
	logic [7:0]               reg_bytes_q [MAP_ENTRIES];
	logic                     expect_ptr_q;
	map_idx_t                 read_target_q;
	logic                     read_valid_q;
	map_idx_t                 write_target_q;
	logic                     write_valid_q;
	logic signed [TEMP_W-1:0] remote_temp_q;
	logic signed [TEMP_W-1:0] local_temp_q;

	logic                     advance;
	logic                     commit;
	ptr_dec_t                 dec;
	logic signed [TEMP_W-1:0] temp_sel;
	logic [7:0]               temp_code;
	logic [7:0]               rd_next;
	logic                     drop_next;

	// handshake
	assign advance = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign commit = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_t'(s_tuser);
			dir_s1 <= s_tdata[0];
			data_s1 <= s_tdata[8:1];
			remote_s1 <= s_tdata[17:9];
			local_s1 <= s_tdata[26:18];
		end
	end

	tsrs_ptr_decode u_ptr_decode (
		.ptr (data_s1),
		.dec (dec)
	);

	// temperature read path
	assign temp_sel = (read_target_q == IDX_REMOTE) ? remote_temp_q : local_temp_q;

	tsrs_temp_encode u_temp_encode (
		.temp     (temp_sel),
		.ext_mode (reg_bytes_q[IDX_CONFIG][EXT_MODE_BIT]),
		.code     (temp_code)
	);

	// result of the item in the input register
	always_comb begin
		rd_next = 8'h00;
		drop_next = 1'b0;
		unique case (req_s1)
			REQ_WRITE: begin
				drop_next = !expect_ptr_q && !write_valid_q;
			end
			REQ_READ: begin
				if (read_valid_q) begin
					if (read_target_q == IDX_REMOTE || read_target_q == IDX_LOCAL) begin
						rd_next = temp_code;
					end else begin
						rd_next = reg_bytes_q[read_target_q];
					end
				end
			end
			default: begin
				rd_next = 8'h00;
			end
		endcase
	end

	// state update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_ENTRIES; i++) begin
				reg_bytes_q[i] <= MAP_INIT[i];
			end
			expect_ptr_q <= 1'b0;
			read_target_q <= IDX_REMOTE;
			read_valid_q <= 1'b1;
			write_target_q <= IDX_REMOTE;
			write_valid_q <= 1'b1;
			remote_temp_q <= '0;
			local_temp_q <= '0;
		end else if (commit) begin
			unique case (req_s1)
				REQ_MATCH: begin
					if (dir_s1) begin
						expect_ptr_q <= 1'b1;
					end
				end
				REQ_WRITE: begin
					if (expect_ptr_q) begin
						expect_ptr_q <= 1'b0;
						read_valid_q <= dec.rd_valid;
						write_valid_q <= dec.wr_valid;
						if (dec.rd_valid) begin
							read_target_q <= dec.rd_idx;
						end
						if (dec.wr_valid) begin
							write_target_q <= dec.wr_idx;
						end
					end else if (write_valid_q) begin
						reg_bytes_q[write_target_q] <= data_s1;
					end
				end
				REQ_TEMP: begin
					remote_temp_q <= remote_s1;
					local_temp_q <= local_s1;
				end
				default: begin
					expect_ptr_q <= expect_ptr_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rd_s2 <= rd_next;
			drop_s2 <= drop_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {{(OUT_DATA_W - 9){1'b0}}, drop_s2, rd_s2};

endmodule
